// ===== hw/rtl/jtsr_pkg.sv =====
// Shared constants, kind codes and message type of the JSON token structure reader.
`default_nettype none
package jtsr_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam int KIND_W  = 4;
   localparam int VALUE_W = 64;
   localparam int LEN_W   = 16;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_IDX_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      TOK_END       = 4'd0,
      TOK_ERROR     = 4'd1,
      TOK_OBJ_OPEN  = 4'd2,
      TOK_OBJ_CLOSE = 4'd3,
      TOK_ARR_OPEN  = 4'd4,
      TOK_ARR_CLOSE = 4'd5,
      TOK_COLON     = 4'd6,
      TOK_COMMA     = 4'd7,
      TOK_STRING    = 4'd8,
      TOK_UNSIGNED  = 4'd9,
      TOK_INTEGER   = 4'd10,
      TOK_FLOAT     = 4'd11,
      TOK_BOOL      = 4'd12,
      TOK_NULL      = 4'd13
   } token_kind_type;

   typedef enum logic [KIND_W-1:0] {
      MSG_END       = 4'd0,
      MSG_ERROR     = 4'd1,
      MSG_OBJ_OPEN  = 4'd2,
      MSG_OBJ_CLOSE = 4'd3,
      MSG_ARR_OPEN  = 4'd4,
      MSG_ARR_CLOSE = 4'd5,
      MSG_NAME      = 4'd6,
      MSG_STRING    = 4'd7,
      MSG_UNSIGNED  = 4'd8,
      MSG_INTEGER   = 4'd9,
      MSG_FLOAT     = 4'd10,
      MSG_BOOL      = 4'd11,
      MSG_NULL      = 4'd12
   } msg_kind_type;

   typedef struct packed {
      msg_kind_type       kind;
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   text_len;
      logic               has_key;
      logic [VALUE_W-1:0] key_ref;
      logic [LEN_W-1:0]   key_len;
      logic               nest_fault;
      logic               last;
   } msg_type;

endpackage
`default_nettype wire

// ===== hw/rtl/jtsr_if.sv =====
// Token and message channel interfaces of the JSON token structure reader.
`default_nettype none
interface jtsr_req_if;
   logic                          valid;
   logic                          ready;
   logic [jtsr_pkg::KIND_W-1:0]   token_kind;
   logic [jtsr_pkg::VALUE_W-1:0]  token_value;
   logic [jtsr_pkg::LEN_W-1:0]    token_text_len;

   modport source (output valid, output token_kind, output token_value,
                   output token_text_len, input ready);
   modport sink (input valid, input token_kind, input token_value,
                 input token_text_len, output ready);
endinterface

interface jtsr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [jtsr_pkg::KIND_W-1:0]   msg_kind;
   logic [jtsr_pkg::VALUE_W-1:0]  msg_value;
   logic [jtsr_pkg::LEN_W-1:0]    msg_text_len;
   logic                          has_key;
   logic [jtsr_pkg::VALUE_W-1:0]  key_ref;
   logic [jtsr_pkg::LEN_W-1:0]    key_len;
   logic                          nest_fault;
   logic                          last;

   modport source (output valid, output msg_kind, output msg_value, output msg_text_len,
                   output has_key, output key_ref, output key_len, output nest_fault,
                   output last, input ready);
   modport sink (input valid, input msg_kind, input msg_value, input msg_text_len,
                 input has_key, input key_ref, input key_len, input nest_fault,
                 input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/json_token_structure_reader_core.sv =====
// Path: a token is captured in the input register, decoded into a 4-entry message queue
// once the queue has room, and its first message is offered on rsp_bus from the queue head.
// Throughput: one token per cycle while the queue has room for two messages; the message side
// drains one message per cycle while rsp_bus.ready is high, so two-message tokens limit the rate.
// Reset: synchronous; empties the nesting stack, the pending key and the queue.
`default_nettype none
module json_token_structure_reader_core (
   input  wire         clock,
   input  wire         reset,
   jtsr_req_if.sink    req_bus,
   jtsr_rsp_if.source  rsp_bus
);

   // input register
   logic                              in_valid_ff;
   jtsr_pkg::token_kind_type          in_kind_ff;
   logic [jtsr_pkg::VALUE_W-1:0]      in_value_ff;
   logic [jtsr_pkg::LEN_W-1:0]        in_len_ff;

   // parser state
   logic                              stack_ff [jtsr_pkg::STACK_DEPTH];
   logic [jtsr_pkg::STACK_CNT_W-1:0]  stack_count_ff, stack_count_in;
   logic [jtsr_pkg::VALUE_W-1:0]      key_ref_ff, key_ref_in;
   logic [jtsr_pkg::LEN_W-1:0]        key_len_ff, key_len_in;
   logic                              colon_ff, colon_in;

   // message queue
   jtsr_pkg::msg_type                 oq_mem_ff [jtsr_pkg::OQ_DEPTH];
   logic [jtsr_pkg::OQ_IDX_W-1:0]     oq_rd_ptr_ff, oq_wr_ptr_ff;
   logic [jtsr_pkg::OQ_CNT_W-1:0]     oq_count_ff, oq_after_pop;

   logic                              oq_pop, oq_room, step, req_xfer;
   logic                              top_obj, push_we, push_obj;
   logic [jtsr_pkg::STACK_IDX_W-1:0]  top_idx, push_idx;
   logic [1:0]                        num_msgs;
   jtsr_pkg::msg_type                 msg0, msg1;

   assign oq_pop       = rsp_bus.valid && rsp_bus.ready;
   assign oq_after_pop = oq_count_ff - jtsr_pkg::OQ_CNT_W'(oq_pop);
   assign oq_room      = oq_after_pop <= jtsr_pkg::OQ_CNT_W'(jtsr_pkg::OQ_DEPTH - 2);
   assign step         = in_valid_ff && oq_room;
   assign req_bus.ready = !in_valid_ff || step;
   assign req_xfer     = req_bus.valid && req_bus.ready;

   assign top_idx  = jtsr_pkg::STACK_IDX_W'(stack_count_ff - 1'b1);
   assign push_idx = jtsr_pkg::STACK_IDX_W'(stack_count_ff);
   assign top_obj  = (stack_count_ff != '0) && stack_ff[top_idx];

   always_comb begin
      jtsr_pkg::msg_type name_msg;
      jtsr_pkg::msg_type main_msg;
      logic              use_key;
      logic              emit_name;

      stack_count_in = stack_count_ff;
      key_ref_in     = key_ref_ff;
      key_len_in     = key_len_ff;
      colon_in       = colon_ff;
      push_we        = 1'b0;
      push_obj       = 1'b0;
      emit_name      = 1'b0;
      use_key        = key_len_ff != '0;
      num_msgs       = 2'd0;

      name_msg          = '0;
      name_msg.kind     = jtsr_pkg::MSG_NAME;
      name_msg.has_key  = 1'b1;
      name_msg.key_ref  = key_ref_ff;
      name_msg.key_len  = key_len_ff;

      main_msg      = '0;
      main_msg.kind = jtsr_pkg::msg_kind_type'(in_kind_ff);

      unique case (in_kind_ff) inside
         jtsr_pkg::TOK_END, jtsr_pkg::TOK_ERROR: begin
            num_msgs = 2'd1;
         end
         jtsr_pkg::TOK_OBJ_OPEN, jtsr_pkg::TOK_ARR_OPEN: begin
            emit_name = colon_ff && top_obj;
            num_msgs  = emit_name ? 2'd2 : 2'd1;
            if (stack_count_ff < jtsr_pkg::STACK_CNT_W'(jtsr_pkg::STACK_DEPTH)) begin
               push_we        = 1'b1;
               push_obj       = in_kind_ff == jtsr_pkg::TOK_OBJ_OPEN;
               stack_count_in = stack_count_ff + 1'b1;
            end else begin
               main_msg.nest_fault = 1'b1;
            end
            key_ref_in = '0;
            key_len_in = '0;
            colon_in   = 1'b0;
         end
         jtsr_pkg::TOK_OBJ_CLOSE, jtsr_pkg::TOK_ARR_CLOSE: begin
            num_msgs = 2'd1;
            if (stack_count_ff != '0) begin
               stack_count_in = stack_count_ff - 1'b1;
            end else begin
               main_msg.nest_fault = 1'b1;
            end
            key_ref_in = '0;
            key_len_in = '0;
            colon_in   = 1'b0;
         end
         jtsr_pkg::TOK_COLON: begin
            colon_in = 1'b1;
         end
         jtsr_pkg::TOK_COMMA: begin
            key_ref_in = '0;
            key_len_in = '0;
            colon_in   = 1'b0;
         end
         jtsr_pkg::TOK_STRING: begin
            if (!top_obj || colon_ff) begin
               num_msgs          = 2'd1;
               main_msg.kind     = jtsr_pkg::MSG_STRING;
               main_msg.value    = in_value_ff;
               main_msg.text_len = in_len_ff;
               main_msg.has_key  = use_key;
               main_msg.key_ref  = use_key ? key_ref_ff : '0;
               main_msg.key_len  = use_key ? key_len_ff : '0;
               if (use_key) begin
                  key_ref_in = '0;
                  key_len_in = '0;
               end
            end else begin
               key_ref_in = in_value_ff;
               key_len_in = in_len_ff;
            end
            colon_in = 1'b0;
         end
         jtsr_pkg::TOK_UNSIGNED, jtsr_pkg::TOK_INTEGER, jtsr_pkg::TOK_FLOAT,
         jtsr_pkg::TOK_BOOL, jtsr_pkg::TOK_NULL: begin
            num_msgs         = 2'd1;
            main_msg.kind    = jtsr_pkg::msg_kind_type'(in_kind_ff - 1'b1);
            main_msg.value   = (in_kind_ff == jtsr_pkg::TOK_NULL) ? '0 : in_value_ff;
            main_msg.has_key = use_key;
            main_msg.key_ref = use_key ? key_ref_ff : '0;
            main_msg.key_len = use_key ? key_len_ff : '0;
            if (use_key) begin
               key_ref_in = '0;
               key_len_in = '0;
            end
            colon_in = 1'b0;
         end
         default: begin
         end
      endcase

      main_msg.last = 1'b1;
      msg0 = emit_name ? name_msg : main_msg;
      msg1 = main_msg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_xfer) begin
         in_kind_ff  <= jtsr_pkg::token_kind_type'(req_bus.token_kind);
         in_value_ff <= req_bus.token_value;
         in_len_ff   <= req_bus.token_text_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= '0;
         key_ref_ff     <= '0;
         key_len_ff     <= '0;
         colon_ff       <= 1'b0;
      end else if (step) begin
         stack_count_ff <= stack_count_in;
         key_ref_ff     <= key_ref_in;
         key_len_ff     <= key_len_in;
         colon_ff       <= colon_in;
      end
      if (step && push_we) begin
         stack_ff[push_idx] <= push_obj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_rd_ptr_ff <= '0;
         oq_wr_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         if (oq_pop) begin
            oq_rd_ptr_ff <= oq_rd_ptr_ff + 1'b1;
         end
         if (step) begin
            oq_wr_ptr_ff <= oq_wr_ptr_ff + jtsr_pkg::OQ_IDX_W'(num_msgs);
            oq_count_ff  <= oq_after_pop + jtsr_pkg::OQ_CNT_W'(num_msgs);
         end else begin
            oq_count_ff  <= oq_after_pop;
         end
      end
      if (step && num_msgs != 2'd0) begin
         oq_mem_ff[oq_wr_ptr_ff] <= msg0;
      end
      if (step && num_msgs == 2'd2) begin
         oq_mem_ff[oq_wr_ptr_ff + 1'b1] <= msg1;
      end
   end

   assign rsp_bus.valid        = oq_count_ff != '0;
   assign rsp_bus.msg_kind     = oq_mem_ff[oq_rd_ptr_ff].kind;
   assign rsp_bus.msg_value    = oq_mem_ff[oq_rd_ptr_ff].value;
   assign rsp_bus.msg_text_len = oq_mem_ff[oq_rd_ptr_ff].text_len;
   assign rsp_bus.has_key      = oq_mem_ff[oq_rd_ptr_ff].has_key;
   assign rsp_bus.key_ref      = oq_mem_ff[oq_rd_ptr_ff].key_ref;
   assign rsp_bus.key_len      = oq_mem_ff[oq_rd_ptr_ff].key_len;
   assign rsp_bus.nest_fault   = oq_mem_ff[oq_rd_ptr_ff].nest_fault;
   assign rsp_bus.last         = oq_mem_ff[oq_rd_ptr_ff].last;

endmodule
`default_nettype wire
